// ===== hw/rtl/gdsp_pkg.sv =====
// Shared types and constants for the 2x2 grid downsampler.
package gdsp_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int SMP_W         = 16;
    localparam int GW_W          = 12;
    localparam int GH_W          = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int SUM_W         = SMP_W + 2;

    // queue depths, powers of two
    localparam int CMD_DEPTH     = 4;
    localparam int CMD_CNT_W     = $clog2(CMD_DEPTH) + 1;
    localparam int OUT_DEPTH     = 4;
    localparam int OUT_CNT_W     = $clog2(OUT_DEPTH) + 1;

    // floor(n / 3) == (n * RECIP3) >> RECIP3_SHIFT for n < 2^17
    localparam int          RECIP3_W     = 17;
    localparam logic [16:0] RECIP3       = 17'd87382;
    localparam int          RECIP3_SHIFT = 18;
    localparam int          PROD_W       = 2 * RECIP3_W;

    typedef enum logic [1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_NODATA      = 2'd2,
        CFG_STRICT      = 2'd3
    } cfg_idx_t;

    typedef logic signed [SMP_W-1:0] smp_t;

    // smp: top left, top right, bottom left, bottom right
    typedef struct packed {
        smp_t [3:0] smp;
        logic       frame_end;
    } pool_cmd_t;

    typedef struct packed {
        smp_t mean_value;
        logic frame_end;
    } pool_res_t;

endpackage

// ===== hw/rtl/gdsp_fifo.sv =====
// Small synchronous queue with occupancy count.
module gdsp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       empty,
    output logic [$clog2(DEPTH):0]     count
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = AW + 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    assign count   = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && !rd_en && count_reg == CNT_W'(DEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && count_reg == '0))
        else $error("queue read while empty");

endmodule

// ===== hw/rtl/gdsp_front.sv =====
// Front end: raster counters, line store and gathering of each 2x2 neighbourhood.
module gdsp_front #(
    parameter int MAX_WIDTH = gdsp_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  gdsp_pkg::smp_t                    sample,
    input  logic [gdsp_pkg::GW_W-1:0]         grid_width,
    input  logic [gdsp_pkg::GH_W-1:0]         grid_height,
    input  logic [gdsp_pkg::CMD_CNT_W-1:0]    cmd_count,
    output logic                              cmd_wr,
    output gdsp_pkg::pool_cmd_t               cmd_data
);

    import gdsp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > GW_W) ? CW + 1 : GW_W;

    logic [SMP_W-1:0] row_mem [MAX_WIDTH];

    logic [CW-1:0]   col_reg;
    logic [CW-1:0]   col_next;
    logic [GH_W-1:0] row_reg;
    logic [GH_W-1:0] row_next;
    smp_t            left_reg;

    smp_t            rd_data_reg;
    logic            stg_valid_reg;
    smp_t            stg_x_reg;
    smp_t            stg_left_reg;
    smp_t            stg_top_prev_reg;
    logic            stg_odd_row_reg;
    logic            stg_odd_col_reg;
    logic            stg_frame_end_reg;

    logic [WW-1:0]   width_ext;
    logic [WW-1:0]   width_eff;
    logic [WW-1:0]   col_inc;
    logic [GH_W-1:0] height_eff;
    logic [GH_W:0]   row_inc;
    logic            last_col;
    logic            last_row;
    logic            odd_col;
    logic            odd_row;
    logic            produce;
    logic            accept;
    smp_t            cur_left;
    smp_t            top_left;
    smp_t            top_right;

    always_comb
    begin
        width_ext = WW'(grid_width);
        if (grid_width == '0)
        begin
            width_eff = WW'(1);
        end
        else if (width_ext > WW'(MAX_WIDTH))
        begin
            width_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
        height_eff = (grid_height == '0) ? GH_W'(1) : grid_height;
    end

    assign col_inc  = WW'(col_reg) + WW'(1);
    assign row_inc  = {1'b0, row_reg} + (GH_W + 1)'(1);
    assign last_col = (col_inc >= width_eff);
    assign last_row = (row_inc >= {1'b0, height_eff});
    assign odd_col  = col_reg[0];
    assign odd_row  = row_reg[0];
    assign produce  = (odd_col || last_col) && (odd_row || last_row);
    assign cur_left = odd_col ? left_reg : sample;

    // room for the staged transaction and the one being accepted
    assign full   = ((CMD_CNT_W + 1)'(cmd_count) + (CMD_CNT_W + 1)'(stg_valid_reg))
                    >= (CMD_CNT_W + 1)'(CMD_DEPTH);
    assign accept = push && !full;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[GH_W-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            stg_valid_reg <= accept && produce;
            if (accept)
            begin
                left_reg <= sample;
            end
        end
    end

    // even rows fill the line store, odd rows read it back one column at a time
    always_ff @(posedge clk)
    begin
        if (accept && !odd_row)
        begin
            row_mem[col_reg] <= sample;
        end
        if (accept && odd_row)
        begin
            rd_data_reg <= row_mem[col_reg];
        end
    end

    // rd_data_reg still holds the previous column's entry at accept time
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_x_reg         <= sample;
            stg_left_reg      <= cur_left;
            stg_top_prev_reg  <= rd_data_reg;
            stg_odd_row_reg   <= odd_row;
            stg_odd_col_reg   <= odd_col;
            stg_frame_end_reg <= last_col && last_row;
        end
    end

    always_comb
    begin
        if (stg_odd_row_reg)
        begin
            top_right = rd_data_reg;
            top_left  = stg_odd_col_reg ? stg_top_prev_reg : rd_data_reg;
        end
        else
        begin
            top_right = stg_x_reg;
            top_left  = stg_left_reg;
        end
        cmd_data.smp[0]   = top_left;
        cmd_data.smp[1]   = top_right;
        cmd_data.smp[2]   = stg_left_reg;
        cmd_data.smp[3]   = stg_x_reg;
        cmd_data.frame_end = stg_frame_end_reg;
    end

    assign cmd_wr = stg_valid_reg;

    a_stage_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid_reg |-> $past(accept))
        else $error("staged neighbourhood without an accepted sample");

    a_frame_end_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_col && last_row) |=> stg_valid_reg)
        else $error("last sample of frame produced no result");

endmodule

// ===== hw/rtl/gdsp_back.sv =====
// Back end: nodata classification, sum and division by the defined count.
module gdsp_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_empty,
    output logic                             cmd_rd,
    input  gdsp_pkg::pool_cmd_t              cmd_data,
    input  gdsp_pkg::smp_t                   nodata_value,
    input  logic                             strict_mode,
    input  logic [gdsp_pkg::OUT_CNT_W-1:0]   out_count,
    output logic                             out_wr,
    output gdsp_pkg::pool_res_t              out_data
);

    import gdsp_pkg::*;

    logic [3:0]          defined;
    logic [2:0]          def_cnt;
    logic signed [SUM_W-1:0] sum_c;
    logic [SUM_W-1:0]    mag_c;

    logic                a_valid_reg;
    logic                a_neg_reg;
    logic [SUM_W-1:0]    a_mag_reg;
    logic [2:0]          a_cnt_reg;
    logic                a_nodata_reg;
    logic                a_frame_end_reg;

    logic [PROD_W-1:0]   prod3;
    logic [SUM_W-1:0]    quot;
    logic [SUM_W-1:0]    res;

    assign cmd_rd = !cmd_empty
                    && (((OUT_CNT_W + 1)'(out_count) + (OUT_CNT_W + 1)'(a_valid_reg))
                        < (OUT_CNT_W + 1)'(OUT_DEPTH));

    always_comb
    begin
        sum_c = '0;
        for (int k = 0; k < 4; k++)
        begin
            defined[k] = (cmd_data.smp[k] != nodata_value);
            if (defined[k])
            begin
                sum_c = sum_c + {{(SUM_W - SMP_W){cmd_data.smp[k][SMP_W-1]}}, cmd_data.smp[k]};
            end
        end
        def_cnt = 3'($countones(defined));
        mag_c   = sum_c[SUM_W-1] ? SUM_W'(-sum_c) : SUM_W'(sum_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= cmd_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_rd)
        begin
            a_neg_reg       <= sum_c[SUM_W-1];
            a_mag_reg       <= mag_c;
            a_cnt_reg       <= def_cnt;
            a_nodata_reg    <= (def_cnt == 3'd0) || (strict_mode && def_cnt != 3'd4);
            a_frame_end_reg <= cmd_data.frame_end;
        end
    end

    // truncation toward zero: divide the magnitude, then restore the sign
    assign prod3 = PROD_W'(a_mag_reg[RECIP3_W-1:0]) * PROD_W'(RECIP3);

    always_comb
    begin
        case (a_cnt_reg)
            3'd1:    quot = a_mag_reg;
            3'd2:    quot = a_mag_reg >> 1;
            3'd3:    quot = SUM_W'(prod3 >> RECIP3_SHIFT);
            3'd4:    quot = a_mag_reg >> 2;
            default: quot = '0;
        endcase
        res = a_neg_reg ? SUM_W'(-quot) : quot;
        out_data.mean_value = a_nodata_reg ? nodata_value : res[SMP_W-1:0];
        out_data.frame_end  = a_frame_end_reg;
    end

    assign out_wr = a_valid_reg;

    a_stage_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> $past(cmd_rd))
        else $error("result stage loaded without a queue read");

    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_wr |-> (out_count < OUT_CNT_W'(OUT_DEPTH)))
        else $error("result written with the output queue full");

endmodule

// ===== hw/rtl/grid_downsample_2x2_nodata.sv =====
// Top level of the 2x2 mean-pooling grid downsampler with nodata handling.
// Samples enter in raster order, one per clock while full is low; the front end
// keeps the column and row counts and a single-port line store of MAX_WIDTH x
// 16 bits holding the even row. A result reaches the output ports from the
// sample completing its 2x2 neighbourhood through line store read and staging,
// the command queue, the sum stage and then the result queue (the divide by
// the defined count is combinational between the sum stage and the result
// queue). full rises when the four-entry command queue between front and back
// end, counting the staged neighbourhood, has no room for another, which happens
// only while results are not popped; the four-entry result queue then fills
// first. Configuration is taken at any time through the cfg channel (cfg_ready
// is always high) but must change only while idle.
module grid_downsample_2x2_nodata #(
    parameter int MAX_WIDTH = gdsp_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  gdsp_pkg::smp_t                    sample,
    output logic                              empty,
    input  logic                              pop,
    output gdsp_pkg::smp_t                    mean_value,
    output logic                              frame_end,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  gdsp_pkg::cfg_idx_t                cfg_index,
    input  logic [gdsp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import gdsp_pkg::*;

    logic [GW_W-1:0]      grid_width_reg;
    logic [GH_W-1:0]      grid_height_reg;
    smp_t                 nodata_value_reg;
    logic                 strict_mode_reg;

    logic                 cmd_wr;
    logic                 cmd_rd;
    logic                 cmd_empty;
    logic [CMD_CNT_W-1:0] cmd_count;
    pool_cmd_t            cmd_wr_data;
    pool_cmd_t            cmd_rd_data;

    logic                 out_wr;
    logic [OUT_CNT_W-1:0] out_count;
    pool_res_t            out_wr_data;
    pool_res_t            out_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg   <= GW_W'(2048);
            grid_height_reg  <= GH_W'(1);
            nodata_value_reg <= '0;
            strict_mode_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg   <= cfg_data[GW_W-1:0];
                CFG_GRID_HEIGHT: grid_height_reg  <= cfg_data[GH_W-1:0];
                CFG_NODATA:      nodata_value_reg <= smp_t'(cfg_data[SMP_W-1:0]);
                CFG_STRICT:      strict_mode_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    gdsp_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample      (sample),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .cmd_count   (cmd_count),
        .cmd_wr      (cmd_wr),
        .cmd_data    (cmd_wr_data)
    );

    gdsp_fifo #(
        .WIDTH ($bits(pool_cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_wr),
        .wr_data (cmd_wr_data),
        .rd_en   (cmd_rd),
        .rd_data (cmd_rd_data),
        .empty   (cmd_empty),
        .count   (cmd_count)
    );

    gdsp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (cmd_empty),
        .cmd_rd       (cmd_rd),
        .cmd_data     (cmd_rd_data),
        .nodata_value (nodata_value_reg),
        .strict_mode  (strict_mode_reg),
        .out_count    (out_count),
        .out_wr       (out_wr),
        .out_data     (out_wr_data)
    );

    gdsp_fifo #(
        .WIDTH ($bits(pool_res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr),
        .wr_data (out_wr_data),
        .rd_en   (pop && !empty),
        .rd_data (out_rd_data),
        .empty   (empty),
        .count   (out_count)
    );

    assign mean_value = out_rd_data.mean_value;
    assign frame_end  = out_rd_data.frame_end;

endmodule
